// ===== design/dcs_pkg.sv =====
`default_nettype none

package dcs_pkg;

	// Fixed-point format
	localparam int FRAC_BITS = 16;
	localparam int GAIN_W    = FRAC_BITS + 1;
	localparam int POS_W     = 18;
	localparam int PRESET_W  = 3;

	localparam logic [GAIN_W-1:0] ONE  = GAIN_W'(1) << FRAC_BITS;
	localparam logic [GAIN_W-1:0] HALF = GAIN_W'(1) << (FRAC_BITS - 1);

	// Default table resolution
	localparam int TABLE_SEGMENTS = 256;

	// Wide format used only while building the tables
	localparam int          W_BITS   = 30;
	localparam logic [63:0] W_ONE    = 64'd1 << W_BITS;
	localparam logic [63:0] ONE_W64  = 64'd1 << FRAC_BITS;
	localparam logic [63:0] PI_W     = (64'd314159265 << W_BITS) / 64'd100000000;

	// Curve constants, round(c * ONE)
	localparam logic [GAIN_W-1:0] TIGHT_KNEE  = GAIN_W'((64'd64 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] PUMP_BASE   = GAIN_W'((64'd176 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] PUMP_DEPTH  = GAIN_W'((64'd24 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] SOFT_SCALE  = GAIN_W'((64'd144 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] HARD_START  = GAIN_W'((64'd32 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] HARD_END    = GAIN_W'((64'd92 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] SIDE_SCALE  = GAIN_W'((64'd184 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] GATE_START  = GAIN_W'((64'd104 * ONE_W64 + 64'd100) / 64'd200);
	localparam logic [GAIN_W-1:0] GATE_END    = GAIN_W'((64'd120 * ONE_W64 + 64'd100) / 64'd200);

	// n / 6 as (n * RECIP6) >> RECIP6_SHIFT, exact for n below 2^21
	localparam int          RECIP6_SHIFT = 22;
	localparam logic [19:0] RECIP6       = 20'(((64'd1 << RECIP6_SHIFT) + 64'd5) / 64'd6);

	typedef enum logic [PRESET_W-1:0] {
		PRE_CLASSIC = 3'd0,
		PRE_TIGHT   = 3'd1,
		PRE_PUMP    = 3'd2,
		PRE_SOFT    = 3'd3,
		PRE_HARD    = 3'd4,
		PRE_LONG    = 3'd5,
		PRE_SIDE    = 3'd6,
		PRE_GATE    = 3'd7
	} preset_t;

	// Table ids; power tables first, in the order of POW_NUM / POW_DEN
	typedef enum logic [2:0] {
		TBL_P190 = 3'd0,
		TBL_P065 = 3'd1,
		TBL_P115 = 3'd2,
		TBL_P135 = 3'd3,
		TBL_P072 = 3'd4,
		TBL_P145 = 3'd5,
		TBL_SIN  = 3'd6
	} tbl_t;

	localparam int TBL_COUNT = 7;

	localparam int unsigned POW_NUM [6] = '{19, 13, 23, 27, 18, 29};
	localparam int unsigned POW_DEN [6] = '{10, 20, 20, 20, 25, 20};

	// Taylor divisors (2k)(2k+1) for k = 1..6
	localparam logic [63:0] SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	// v^k in Q.30, truncating each product
	function automatic logic [63:0] wpow(input logic [63:0] v, input int unsigned k);
		logic [63:0] r;
		int unsigned j;
		r = W_ONE;
		for (j = 0; j < k; j++) begin
			r = (r * v) >> W_BITS;
		end
		return r;
	endfunction

	// Q.30 to gain format, rounded
	function automatic logic [GAIN_W-1:0] w_to_fx(input logic [63:0] y);
		logic [63:0] t;
		t = (y + (64'd1 << (W_BITS - FRAC_BITS - 1))) >> (W_BITS - FRAC_BITS);
		return t[GAIN_W-1:0];
	endfunction

	// Largest y in [0, 1] with y^d <= u^n, bisection over Q.30
	function automatic logic [GAIN_W-1:0] pow_entry(input logic [63:0] u,
	                                                input int unsigned n,
	                                                input int unsigned d);
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		int          step;
		target = wpow(u, n);
		lo     = 64'd0;
		hi     = W_ONE;
		for (step = 0; step < 32; step++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (wpow(mid, d) <= target) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		return w_to_fx(lo);
	endfunction

	// sin(pi * t) for t in Q.30, Taylor series up to a^13
	function automatic logic [GAIN_W-1:0] sin_entry(input logic [63:0] t);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] s;
		int          k;
		a    = (PI_W * t) >> W_BITS;
		a2   = (a * a) >> W_BITS;
		term = a;
		s    = a;
		for (k = 0; k < 6; k++) begin
			term = ((term * a2) >> W_BITS) / SIN_DIV[k];
			if (k % 2 == 0) begin
				s = (s >= term) ? s - term : 64'd0;
			end else begin
				s = s + term;
			end
		end
		if (s > W_ONE) begin
			s = W_ONE;
		end
		return w_to_fx(s);
	endfunction

	// Saturate to ONE
	function automatic logic [GAIN_W-1:0] clamp_one(input logic [31:0] v);
		return (v > 32'(ONE)) ? ONE : v[GAIN_W-1:0];
	endfunction

	// Linear interpolation between two table entries
	function automatic logic [GAIN_W-1:0] lerp(input logic [GAIN_W-1:0] a,
	                                           input logic [GAIN_W-1:0] b,
	                                           input logic [FRAC_BITS-1:0] f);
		logic [GAIN_W-1:0]           diff;
		logic [GAIN_W+FRAC_BITS-1:0] prod;
		logic [GAIN_W-1:0]           adj;
		diff = (b >= a) ? b - a : a - b;
		prod = (GAIN_W + FRAC_BITS)'(diff) * (GAIN_W + FRAC_BITS)'(f)
		       + (GAIN_W + FRAC_BITS)'(HALF);
		adj  = prod[GAIN_W+FRAC_BITS-1:FRAC_BITS];
		return (b >= a) ? a + adj : a - adj;
	endfunction

endpackage

`default_nettype wire

// ===== design/dcs_cfg_if.sv =====
`default_nettype none

interface dcs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [dcs_pkg::PRESET_W-1:0] curve_preset;

	modport source (output valid, output curve_preset, input ready);
	modport sink (input valid, input curve_preset, output ready);
endinterface

`default_nettype wire

// ===== design/dcs_pos_if.sv =====
`default_nettype none

interface dcs_pos_if;
	logic                             valid;
	logic                             ready;
	logic signed [dcs_pkg::POS_W-1:0] curve_position;

	modport source (output valid, output curve_position, input ready);
	modport sink (input valid, input curve_position, output ready);
endinterface

`default_nettype wire

// ===== design/dcs_gain_if.sv =====
`default_nettype none

interface dcs_gain_if;
	logic                       valid;
	logic                       ready;
	logic [dcs_pkg::GAIN_W-1:0] duck_gain;
	logic [dcs_pkg::GAIN_W-1:0] volume_gain;

	modport source (output valid, output duck_gain, output volume_gain, input ready);
	modport sink (input valid, input duck_gain, input volume_gain, output ready);
endinterface

`default_nettype wire

// ===== design/ducking_curve_shaper_top.sv =====
// Throughput: one beat per cycle unless the gain side stalls; eight register stages.
// A stall on the gain side holds every stage in place; the position side waits with it.
// Reset clears all stage valid bits and returns the curve preset to classic.
// The curve tables are constant logic, built at elaboration.
`default_nettype none

module ducking_curve_shaper_top #(
	parameter int TABLE_SEGMENTS = dcs_pkg::TABLE_SEGMENTS
) (
	input wire          clk,
	input wire          arst_n,
	dcs_cfg_if.sink     cfg,
	dcs_pos_if.sink     pos,
	dcs_gain_if.source  gain
);

	localparam int GW   = dcs_pkg::GAIN_W;
	localparam int FB   = dcs_pkg::FRAC_BITS;
	localparam int IW   = $clog2(TABLE_SEGMENTS + 1);
	localparam int PW   = FB + IW;
	localparam int R1_W = 19;
	localparam int N4_W = 21;
	localparam int G7_W = 20;
	localparam int Q4_W = 19;
	localparam int MP_W = N4_W + 20;

	localparam logic [GW-1:0] ONE       = dcs_pkg::ONE;
	localparam logic [GW:0]   THREE_ONE = (GW + 1)'(3) << FB;

	// ---------------------------------------------------------------
	// Curve tables
	// ---------------------------------------------------------------
	wire [GW-1:0] rom_w [dcs_pkg::TBL_COUNT][TABLE_SEGMENTS+1];

	for (genvar gt = 0; gt < dcs_pkg::TBL_COUNT; gt++) begin : g_tbl
		for (genvar gi = 0; gi <= TABLE_SEGMENTS; gi++) begin : g_ent
			if (gt == int'(dcs_pkg::TBL_SIN)) begin : g_sin
				localparam int MI = (gi <= TABLE_SEGMENTS - gi) ? gi : TABLE_SEGMENTS - gi;
				localparam logic [63:0] TW = (64'(MI) << dcs_pkg::W_BITS) / TABLE_SEGMENTS;
				localparam logic [GW-1:0] V = dcs_pkg::sin_entry(TW);
				assign rom_w[gt][gi] = V;
			end else begin : g_pow
				localparam logic [63:0] UW = (64'(gi) << dcs_pkg::W_BITS) / TABLE_SEGMENTS;
				localparam logic [GW-1:0] V =
					dcs_pkg::pow_entry(UW, dcs_pkg::POW_NUM[gt], dcs_pkg::POW_DEN[gt]);
				assign rom_w[gt][gi] = V;
			end
		end
	end

	// ---------------------------------------------------------------
	// Config register and handshake
	// ---------------------------------------------------------------
	dcs_pkg::preset_t preset_q;
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign cfg.ready = 1'b1;
	assign en        = !v_s8 || gain.ready;
	assign pos.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= dcs_pkg::PRE_CLASSIC;
		end else if (cfg.valid) begin
			preset_q <= dcs_pkg::preset_t'(cfg.curve_preset);
		end
	end

	// valid bits move with the data, all stages stall together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= pos.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: clamp position to 0..ONE
	// ---------------------------------------------------------------
	logic [GW-1:0]    x_in;
	logic [GW-1:0]    x_s1;
	dcs_pkg::preset_t pre_s1;

	assign x_in = pos.curve_position[dcs_pkg::POS_W-1] ? '0 :
	              dcs_pkg::clamp_one(32'(pos.curve_position[GW-1:0]));

	// ---------------------------------------------------------------
	// Stage 2: x^2, ramp numerators, knee compares
	// ---------------------------------------------------------------
	logic [2*GW-1:0]  sq;
	logic [21:0]      r1_full;
	logic [GW-1:0]    d4;
	logic [GW-1:0]    d7;
	logic [G7_W:0]    g7_full;
	logic [GW-1:0]    x_s2;
	logic [GW-1:0]    x2_s2;
	logic [R1_W-1:0]  r1_s2;
	logic [N4_W-1:0]  n4_s2;
	logic [G7_W-1:0]  g7_s2;
	logic             lt_tight_s2, lt_hs_s2, lt_he_s2, lt_gs_s2, lt_ge_s2;
	dcs_pkg::preset_t pre_s2;

	assign sq      = (2*GW)'(x_s1) * (2*GW)'(x_s1) + (2*GW)'(dcs_pkg::HALF);
	assign r1_full = 22'(x_s1) * 22'd25 + 22'd4;
	assign d4      = x_s1 - dcs_pkg::HARD_START;
	assign d7      = x_s1 - dcs_pkg::GATE_START;
	assign g7_full = (G7_W + 1)'(d7) * (G7_W + 1)'(25) + (G7_W + 1)'(1);

	// ---------------------------------------------------------------
	// Stage 3: smoothstep, ramp results, table argument
	// ---------------------------------------------------------------
	logic [GW:0]         k3;
	logic [2*GW:0]       m3;
	logic [MP_W-1:0]     q4_full;
	logic [Q4_W-1:0]     q4;
	logic [GW-1:0]       ramp4, ramp7;
	logic [GW-1:0]       arg3;
	logic [GW-1:0]       dir3;
	logic                use3;
	logic [GW-1:0]       x_s3;
	logic [GW-1:0]       ss_s3;
	logic [GW-1:0]       arg_s3;
	logic [GW-1:0]       dir_s3;
	logic                use_s3;
	dcs_pkg::preset_t    pre_s3;

	assign k3      = THREE_ONE - {x_s2, 1'b0};
	assign m3      = (2*GW + 1)'(x2_s2) * (2*GW + 1)'(k3) + (2*GW + 1)'(dcs_pkg::HALF);
	assign q4_full = MP_W'(n4_s2) * MP_W'(dcs_pkg::RECIP6);
	assign q4      = q4_full[dcs_pkg::RECIP6_SHIFT +: Q4_W];
	assign ramp4   = ONE - dcs_pkg::clamp_one(32'(q4));
	assign ramp7   = ONE - dcs_pkg::clamp_one(32'(g7_s2));

	// table argument for the tight knee, else 1-x
	assign arg3 = (pre_s2 == dcs_pkg::PRE_TIGHT) ?
	              ONE - dcs_pkg::clamp_one(32'(r1_s2)) : ONE - x_s2;

	// presets that bypass the tables
	always_comb begin
		dir3 = '0;
		use3 = 1'b0;
		unique case (pre_s2)
			dcs_pkg::PRE_TIGHT: begin
				use3 = !lt_tight_s2;
			end
			dcs_pkg::PRE_HARD: begin
				use3 = 1'b1;
				if (lt_hs_s2) begin
					dir3 = ONE;
				end else if (lt_he_s2) begin
					dir3 = ramp4;
				end
			end
			dcs_pkg::PRE_GATE: begin
				use3 = 1'b1;
				if (lt_gs_s2) begin
					dir3 = ONE;
				end else if (lt_ge_s2) begin
					dir3 = ramp7;
				end
			end
			default: begin
				use3 = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Stage 4: table index and fraction
	// ---------------------------------------------------------------
	logic [GW-1:0]    arg4;
	logic [PW-1:0]    mpos4, spos4;
	logic [IW-1:0]    idx_s4, sidx_s4;
	logic [FB-1:0]    frac_s4, sfrac_s4;
	logic [GW-1:0]    dir_s4;
	logic             use_s4;
	dcs_pkg::preset_t pre_s4;

	assign arg4  = (pre_s3 == dcs_pkg::PRE_SOFT) ? ONE - ss_s3 : arg_s3;
	assign mpos4 = PW'(arg4) * PW'(TABLE_SEGMENTS);
	assign spos4 = PW'(x_s3) * PW'(TABLE_SEGMENTS);

	// ---------------------------------------------------------------
	// Stage 5: table reads
	// ---------------------------------------------------------------
	dcs_pkg::tbl_t    tsel;
	logic [IW-1:0]    nxt5, snxt5;
	logic [GW-1:0]    a_s5, b_s5, sa_s5, sb_s5;
	logic [FB-1:0]    frac_s5, sfrac_s5;
	logic [GW-1:0]    dir_s5;
	logic             use_s5;
	dcs_pkg::preset_t pre_s5;

	always_comb begin
		unique case (pre_s4)
			dcs_pkg::PRE_CLASSIC: tsel = dcs_pkg::TBL_P190;
			dcs_pkg::PRE_TIGHT:   tsel = dcs_pkg::TBL_P065;
			dcs_pkg::PRE_PUMP:    tsel = dcs_pkg::TBL_P115;
			dcs_pkg::PRE_SOFT:    tsel = dcs_pkg::TBL_P135;
			dcs_pkg::PRE_LONG:    tsel = dcs_pkg::TBL_P072;
			dcs_pkg::PRE_SIDE:    tsel = dcs_pkg::TBL_P145;
			default:              tsel = dcs_pkg::TBL_P190;
		endcase
	end

	// last entry interpolates with itself
	assign nxt5  = (idx_s4 == IW'(TABLE_SEGMENTS)) ? idx_s4 : idx_s4 + IW'(1);
	assign snxt5 = (sidx_s4 == IW'(TABLE_SEGMENTS)) ? sidx_s4 : sidx_s4 + IW'(1);

	// ---------------------------------------------------------------
	// Stage 6: interpolation
	// ---------------------------------------------------------------
	logic [GW-1:0]    p_s6, sn_s6;
	logic [GW-1:0]    dir_s6;
	logic             use_s6;
	dcs_pkg::preset_t pre_s6;

	// ---------------------------------------------------------------
	// Stage 7: scale by constant, or build the pump ripple factor
	// ---------------------------------------------------------------
	logic [GW-1:0]    coef7, opnd7;
	logic [2*GW-1:0]  m7;
	logic [GW:0]      res7;
	logic [GW-1:0]    q7;
	logic [GW-1:0]    p_s7, q_s7;
	logic [GW-1:0]    dir_s7;
	logic             use_s7;
	dcs_pkg::preset_t pre_s7;

	always_comb begin
		coef7 = ONE;
		opnd7 = p_s6;
		unique case (pre_s6)
			dcs_pkg::PRE_PUMP: begin
				coef7 = dcs_pkg::PUMP_DEPTH;
				opnd7 = sn_s6;
			end
			dcs_pkg::PRE_SOFT: begin
				coef7 = dcs_pkg::SOFT_SCALE;
			end
			dcs_pkg::PRE_SIDE: begin
				coef7 = dcs_pkg::SIDE_SCALE;
			end
			default: begin
				coef7 = ONE;
			end
		endcase
	end

	assign m7   = (2*GW)'(coef7) * (2*GW)'(opnd7) + (2*GW)'(dcs_pkg::HALF);
	assign res7 = m7[FB +: GW+1];
	assign q7   = (pre_s6 == dcs_pkg::PRE_PUMP) ? dcs_pkg::PUMP_BASE + res7[GW-1:0] :
	              dcs_pkg::clamp_one(32'(res7));

	// ---------------------------------------------------------------
	// Stage 8: pump product, final select, output register
	// ---------------------------------------------------------------
	logic [2*GW-1:0] m8;
	logic [GW-1:0]   duck8;
	logic [GW-1:0]   duck_s8, vol_s8;

	assign m8 = (2*GW)'(p_s7) * (2*GW)'(q_s7) + (2*GW)'(dcs_pkg::HALF);

	always_comb begin
		if (use_s7) begin
			duck8 = dir_s7;
		end else if (pre_s7 == dcs_pkg::PRE_PUMP) begin
			duck8 = dcs_pkg::clamp_one(32'(m8[FB +: GW+1]));
		end else begin
			duck8 = q_s7;
		end
	end

	// pipeline payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			x_s1   <= x_in;
			pre_s1 <= preset_q;
			// stage 2
			x_s2        <= x_s1;
			x2_s2       <= sq[FB +: GW];
			r1_s2       <= r1_full[21:3];
			n4_s2       <= N4_W'(d4) * N4_W'(20) + N4_W'(3);
			g7_s2       <= g7_full[G7_W:1];
			lt_tight_s2 <= x_s1 < dcs_pkg::TIGHT_KNEE;
			lt_hs_s2    <= x_s1 < dcs_pkg::HARD_START;
			lt_he_s2    <= x_s1 < dcs_pkg::HARD_END;
			lt_gs_s2    <= x_s1 < dcs_pkg::GATE_START;
			lt_ge_s2    <= x_s1 < dcs_pkg::GATE_END;
			pre_s2      <= pre_s1;
			// stage 3
			x_s3   <= x_s2;
			ss_s3  <= dcs_pkg::clamp_one(32'(m3[FB +: GW+2]));
			arg_s3 <= arg3;
			dir_s3 <= dir3;
			use_s3 <= use3;
			pre_s3 <= pre_s2;
			// stage 4
			idx_s4   <= mpos4[PW-1:FB];
			frac_s4  <= mpos4[FB-1:0];
			sidx_s4  <= spos4[PW-1:FB];
			sfrac_s4 <= spos4[FB-1:0];
			dir_s4   <= dir_s3;
			use_s4   <= use_s3;
			pre_s4   <= pre_s3;
			// stage 5
			a_s5     <= rom_w[tsel][idx_s4];
			b_s5     <= rom_w[tsel][nxt5];
			sa_s5    <= rom_w[dcs_pkg::TBL_SIN][sidx_s4];
			sb_s5    <= rom_w[dcs_pkg::TBL_SIN][snxt5];
			frac_s5  <= frac_s4;
			sfrac_s5 <= sfrac_s4;
			dir_s5   <= dir_s4;
			use_s5   <= use_s4;
			pre_s5   <= pre_s4;
			// stage 6
			p_s6   <= dcs_pkg::lerp(a_s5, b_s5, frac_s5);
			sn_s6  <= dcs_pkg::lerp(sa_s5, sb_s5, sfrac_s5);
			dir_s6 <= dir_s5;
			use_s6 <= use_s5;
			pre_s6 <= pre_s5;
			// stage 7
			p_s7   <= p_s6;
			q_s7   <= q7;
			dir_s7 <= dir_s6;
			use_s7 <= use_s6;
			pre_s7 <= pre_s6;
			// stage 8
			duck_s8 <= duck8;
			vol_s8  <= ONE - duck8;
		end
	end

	assign gain.valid       = v_s8;
	assign gain.duck_gain   = duck_s8;
	assign gain.volume_gain = vol_s8;

endmodule

`default_nettype wire

// ===== sim/tb_ducking_curve_shaper_top.sv =====
`default_nettype none

module tb_ducking_curve_shaper_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dcs_pkg::*;

	localparam logic [63:0] UNIT        = 64'd1 << FRAC_BITS;
	localparam int          STALL_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          PHASES      = 12;
	localparam int          PHASE_ITEMS = 62;
	localparam int          HOLD_PHASE  = 4;
	localparam int          PAUSE_PHASE = 6;
	localparam int          DIR_ROWS    = 25;

	// Exponent n/d of each power table, in table id order
	localparam int unsigned EXP_NUM [6] = '{19, 13, 23, 27, 18, 29};
	localparam int unsigned EXP_DEN [6] = '{10, 20, 20, 20, 25, 20};

	// Knees of the shapes and the clamp edges of the position
	localparam int KEY_POINTS [7]  = '{0, 10486, 20972, 30147, 34079, 39322, 65536};
	localparam int EDGE_POINTS [8] = '{-131072, -1, 0, 1, 65535, 65536, 65537, 131071};

	typedef struct packed {
		logic [GAIN_W-1:0] duck;
		logic [GAIN_W-1:0] vol;
	} gain_pair_t;

	typedef struct {
		preset_t           preset;
		int                pos;
		bit                known;
		logic [GAIN_W-1:0] duck;
		logic [GAIN_W-1:0] vol;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dcs_cfg_if  cfg_if ();
	dcs_pos_if  pos_if ();
	dcs_gain_if gain_if ();

	ducking_curve_shaper_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.pos    (pos_if),
		.gain   (gain_if)
	);

	logic [GAIN_W-1:0] curve_tbl [TBL_COUNT][TABLE_SEGMENTS+1];

	gain_pair_t gain_expect_q [$];
	preset_t    active_preset = PRE_CLASSIC;
	int         err_count     = 0;
	int         idle_cycles   = 0;

	// Staged with the position beat on the bus; typed-in result for directed rows
	bit         stage_known = 1'b0;
	gain_pair_t stage_pair  = '0;

	// Receiver control, written by the stimulus process only
	int rx_ready_pct  = 100;
	int hold_requests = 0;

	// Directed rows: clamps, knees and flat regions of each shape
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{PRE_CLASSIC, -131072, 1'b1, 17'd65536, 17'd0},
		'{PRE_CLASSIC, 0,       1'b1, 17'd65536, 17'd0},
		'{PRE_CLASSIC, 65536,   1'b0, 17'd0,     17'd0},
		'{PRE_CLASSIC, 131071,  1'b0, 17'd0,     17'd0},
		'{PRE_TIGHT,   0,       1'b1, 17'd65536, 17'd0},
		'{PRE_TIGHT,   20971,   1'b0, 17'd0,     17'd0},
		'{PRE_TIGHT,   20972,   1'b1, 17'd0,     17'd65536},
		'{PRE_PUMP,    0,       1'b0, 17'd0,     17'd0},
		'{PRE_PUMP,    32768,   1'b0, 17'd0,     17'd0},
		'{PRE_PUMP,    65536,   1'b0, 17'd0,     17'd0},
		'{PRE_SOFT,    32768,   1'b0, 17'd0,     17'd0},
		'{PRE_SOFT,    65536,   1'b0, 17'd0,     17'd0},
		'{PRE_HARD,    10485,   1'b1, 17'd65536, 17'd0},
		'{PRE_HARD,    10486,   1'b0, 17'd0,     17'd0},
		'{PRE_HARD,    30146,   1'b0, 17'd0,     17'd0},
		'{PRE_HARD,    30147,   1'b1, 17'd0,     17'd65536},
		'{PRE_LONG,    0,       1'b1, 17'd65536, 17'd0},
		'{PRE_LONG,    49152,   1'b0, 17'd0,     17'd0},
		'{PRE_SIDE,    0,       1'b1, 17'd60293, 17'd5243},
		'{PRE_SIDE,    65536,   1'b0, 17'd0,     17'd0},
		'{PRE_GATE,    34078,   1'b1, 17'd65536, 17'd0},
		'{PRE_GATE,    34079,   1'b0, 17'd0,     17'd0},
		'{PRE_GATE,    39321,   1'b0, 17'd0,     17'd0},
		'{PRE_GATE,    39322,   1'b1, 17'd0,     17'd65536},
		'{PRE_GATE,    -1,      1'b1, 17'd65536, 17'd0}
	};

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Q.30 power with every product truncated
	function automatic logic [63:0] q30_power(input logic [63:0] v, input int unsigned k);
		logic [63:0] acc;
		acc = W_ONE;
		for (int j = 0; j < k; j++) begin
			acc = (acc * v) >> W_BITS;
		end
		return acc;
	endfunction

	function automatic logic [GAIN_W-1:0] q30_to_gain(input logic [63:0] y);
		return GAIN_W'((y + (64'd1 << (W_BITS - FRAC_BITS - 1))) >> (W_BITS - FRAC_BITS));
	endfunction

	// sin(pi*t), Taylor series to the 13th power, saturating subtraction
	function automatic logic [63:0] q30_sin_pi(input logic [63:0] t);
		logic [63:0] pi_q30;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] acc;
		pi_q30 = (64'd314159265 << W_BITS) / 64'd100000000;
		a      = (pi_q30 * t) >> W_BITS;
		a2     = (a * a) >> W_BITS;
		term   = a;
		acc    = a;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * a2) >> W_BITS) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		return (acc > W_ONE) ? W_ONE : acc;
	endfunction

	task automatic fill_curve_tables();
		logic [63:0] u;
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		int          m;
		// power tables: largest y with y^d <= u^n
		for (int t = 0; t < 6; t++) begin
			for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
				u      = (64'(i) << W_BITS) / TABLE_SEGMENTS;
				target = q30_power(u, EXP_NUM[t]);
				lo     = 64'd0;
				hi     = W_ONE;
				while (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (q30_power(mid, EXP_DEN[t]) <= target) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
				curve_tbl[t][i] = q30_to_gain(lo);
			end
		end
		// sine table, folded around the midpoint
		for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
			m = (i <= TABLE_SEGMENTS - i) ? i : TABLE_SEGMENTS - i;
			curve_tbl[int'(TBL_SIN)][i] = q30_to_gain(q30_sin_pi((64'(m) << W_BITS) / TABLE_SEGMENTS));
		end
	endtask

	function automatic logic [63:0] sat_unit(input logic [63:0] v);
		return (v > UNIT) ? UNIT : v;
	endfunction

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (UNIT >> 1)) >> FRAC_BITS;
	endfunction

	// round(n/d) in gain format
	function automatic logic [63:0] fx_const(input int unsigned n, input int unsigned d);
		return (64'(n) * UNIT * 64'd2 + 64'(d)) / (64'(d) * 64'd2);
	endfunction

	function automatic logic [63:0] tbl_lerp(input tbl_t t, input logic [63:0] v);
		logic [63:0] span;
		logic [63:0] idx;
		logic [63:0] f;
		logic [63:0] a;
		logic [63:0] b;
		span = sat_unit(v) * TABLE_SEGMENTS;
		idx  = span >> FRAC_BITS;
		f    = span & (UNIT - 64'd1);
		if (idx >= TABLE_SEGMENTS) begin
			return 64'(curve_tbl[int'(t)][TABLE_SEGMENTS]);
		end
		a = 64'(curve_tbl[int'(t)][int'(idx)]);
		b = 64'(curve_tbl[int'(t)][int'(idx) + 1]);
		if (b >= a) begin
			return a + (((b - a) * f + (UNIT >> 1)) >> FRAC_BITS);
		end
		return a - (((a - b) * f + (UNIT >> 1)) >> FRAC_BITS);
	endfunction

	// Duck and volume gain for one position under one preset
	function automatic gain_pair_t predict_gains(input preset_t preset,
	                                             input logic signed [POS_W-1:0] p);
		logic [63:0] x;
		logic [63:0] u;
		logic [63:0] g;
		logic [63:0] pw;
		logic [63:0] fac;
		logic [63:0] x2;
		logic [63:0] s;
		gain_pair_t  r;
		x = p[POS_W-1] ? 64'd0 : sat_unit(64'(p[POS_W-2:0]));
		u = UNIT - x;
		case (preset)
			PRE_CLASSIC: begin
				g = tbl_lerp(TBL_P190, u);
			end
			PRE_TIGHT: begin
				if (x < fx_const(32, 100)) begin
					g = tbl_lerp(TBL_P065, UNIT - sat_unit((x * 25 + 4) >> 3));
				end else begin
					g = 64'd0;
				end
			end
			PRE_PUMP: begin
				pw  = tbl_lerp(TBL_P115, u);
				fac = fx_const(88, 100) + fx_mul(fx_const(12, 100), tbl_lerp(TBL_SIN, x));
				g   = fx_mul(pw, fac);
			end
			PRE_SOFT: begin
				x2 = fx_mul(x, x);
				s  = sat_unit(fx_mul(x2, 3 * UNIT - 2 * x));
				g  = fx_mul(fx_const(72, 100), tbl_lerp(TBL_P135, UNIT - s));
			end
			PRE_HARD: begin
				if (x < fx_const(16, 100)) begin
					g = UNIT;
				end else if (x < fx_const(46, 100)) begin
					g = UNIT - sat_unit(((x - fx_const(16, 100)) * 20 + 3) / 6);
				end else begin
					g = 64'd0;
				end
			end
			PRE_LONG: begin
				g = tbl_lerp(TBL_P072, u);
			end
			PRE_SIDE: begin
				g = fx_mul(fx_const(92, 100), tbl_lerp(TBL_P145, u));
			end
			default: begin
				if (x < fx_const(52, 100)) begin
					g = UNIT;
				end else if (x < fx_const(60, 100)) begin
					g = UNIT - sat_unit(((x - fx_const(52, 100)) * 25 + 1) >> 1);
				end else begin
					g = 64'd0;
				end
			end
		endcase
		g      = sat_unit(g);
		r.duck = GAIN_W'(g);
		r.vol  = GAIN_W'(UNIT - g);
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		err_count++;
	endtask

	// Beat monitor: tracks the preset, queues expectations, checks gain beats
	always @(posedge clk) begin
		gain_pair_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				active_preset = preset_t'(cfg_if.curve_preset);
			end
			if (pos_if.valid && pos_if.ready) begin
				if (stage_known) begin
					gain_expect_q.push_back(stage_pair);
				end else begin
					gain_expect_q.push_back(predict_gains(active_preset, pos_if.curve_position));
				end
			end
			if (gain_if.valid && gain_if.ready) begin
				if (gain_expect_q.size() == 0) begin
					report_error($sformatf("gain beat with nothing expected: duck %0d vol %0d",
					                       gain_if.duck_gain, gain_if.volume_gain));
				end else begin
					want = gain_expect_q.pop_front();
					if (gain_if.duck_gain !== want.duck) begin
						report_error($sformatf("duck_gain %0d, expected %0d",
						                       gain_if.duck_gain, want.duck));
					end
					if (gain_if.volume_gain !== want.vol) begin
						report_error($sformatf("volume_gain %0d, expected %0d",
						                       gain_if.volume_gain, want.vol));
					end
				end
			end
		end
	end

	// Watchdog: cycles without any beat
	always @(posedge clk) begin
		if ((cfg_if.valid && cfg_if.ready) || (pos_if.valid && pos_if.ready) ||
		    (gain_if.valid && gain_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random ready runs, plus long hold-offs on request
	initial begin
		int run_left;
		int hold_left;
		int served;
		bit level;
		run_left  = 0;
		hold_left = 0;
		served    = 0;
		level     = 1'b1;
		gain_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served    = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				gain_if.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					level    = ($urandom_range(0, 99) < rx_ready_pct);
					run_left = $urandom_range(1, 5);
				end
				run_left--;
				gain_if.ready <= level;
			end
		end
	end

	// Offer one position beat and wait for it to be taken; returns at a falling edge
	task automatic send_position(input logic signed [POS_W-1:0] p, input bit known,
	                             input gain_pair_t pair);
		stage_known = known;
		stage_pair  = pair;
		pos_if.valid          <= 1'b1;
		pos_if.curve_position <= p;
		do begin
			@(posedge clk);
		end while (!(pos_if.valid && pos_if.ready));
		@(negedge clk);
	endtask

	task automatic pos_gap(input int cycles);
		pos_if.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Hold the position side until every queued gain beat has arrived
	task automatic drain_gains();
		pos_if.valid <= 1'b0;
		while (gain_expect_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_preset(input preset_t p);
		cfg_if.valid        <= 1'b1;
		cfg_if.curve_preset <= p;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic signed [POS_W-1:0] rand_position();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			return POS_W'($urandom);
		end else if (sel < 65) begin
			return POS_W'($urandom_range(0, 65536));
		end else if (sel < 85) begin
			return POS_W'(KEY_POINTS[$urandom_range(0, 6)] + int'($urandom_range(0, 16)) - 8);
		end else if (sel < 95) begin
			return POS_W'(EDGE_POINTS[$urandom_range(0, 7)]);
		end
		return POS_W'(-int'($urandom_range(1, 131072)));
	endfunction

	// Stimulus
	initial begin
		preset_t    drive_preset;
		preset_t    next_preset;
		gain_pair_t pair;
		int         burst_left;
		bit         no_gaps;
		pos_if.valid          = 1'b0;
		pos_if.curve_position = '0;
		cfg_if.valid          = 1'b0;
		cfg_if.curve_preset   = PRE_CLASSIC;
		arst_n                = 1'b0;
		drive_preset          = PRE_CLASSIC;
		burst_left            = 0;
		fill_curve_tables();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows; preset changes only with the pipeline empty
		rx_ready_pct = 80;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].preset != drive_preset) begin
				drain_gains();
				write_preset(dir_rows[i].preset);
				drive_preset = dir_rows[i].preset;
			end
			pair.duck = dir_rows[i].duck;
			pair.vol  = dir_rows[i].vol;
			send_position(POS_W'(dir_rows[i].pos), dir_rows[i].known, pair);
			if ($urandom_range(0, 3) == 0) begin
				pos_gap($urandom_range(1, 4));
			end
		end

		// random phases, one preset each; classic and gate first for the extremes
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_gains();
			if (ph == 0) begin
				next_preset = PRE_CLASSIC;
			end else if (ph == 1) begin
				next_preset = PRE_GATE;
			end else begin
				next_preset = preset_t'($urandom_range(0, 7));
			end
			write_preset(next_preset);
			drive_preset = next_preset;
			case ($urandom_range(0, 3))
				0: rx_ready_pct = 100;
				1: rx_ready_pct = 80;
				2: rx_ready_pct = 50;
				default: rx_ready_pct = 25;
			endcase
			no_gaps = (ph == 2) || (ph == HOLD_PHASE);
			if (ph == 2) begin
				rx_ready_pct = 100;
			end
			if (ph == HOLD_PHASE) begin
				rx_ready_pct = 100;
				hold_requests++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
					drain_gains();
				end
				if (!no_gaps && burst_left == 0) begin
					pos_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 12);
				end
				send_position(rand_position(), 1'b0, '0);
				if (burst_left > 0) begin
					burst_left--;
				end
			end
		end

		drain_gains();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== ducking_curve_shaper_top.f =====
design/dcs_pkg.sv
design/dcs_cfg_if.sv
design/dcs_pos_if.sv
design/dcs_gain_if.sv
design/ducking_curve_shaper_top.sv
sim/tb_ducking_curve_shaper_top.sv
